[rtl/core/b64sc_pkg.sv]
package b64sc_pkg;

    // One accepted input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    // One delivered result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       empty_res;
        logic       bad_char;
    } out_item_t;

    // Class of a character seen by the decoder.
    typedef enum logic [1:0] {
        CLS_DATA,
        CLS_PAD,
        CLS_BAD
    } char_class_t;

    // A finished group handed from the front end to the back end.
    // In encode mode used is the index of the last real character (1 to 3);
    // in decode mode nbytes is the number of whole bytes (0 to 3).
    typedef struct packed {
        logic        decode;
        logic [23:0] bits;
        logic [1:0]  used;
        logic [1:0]  nbytes;
        logic        last;
        logic        bad;
    } group_job_t;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cls;
        if (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h2B, 8'h2F}) begin
            cls = CLS_DATA;
        end else if (c == PAD_CHAR) begin
            cls = CLS_PAD;
        end else begin
            cls = CLS_BAD;
        end
        return cls;
    endfunction

    // Sextet value of an alphabet character; zero for anything else.
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h41:8'h5A]}) begin
            v = c - 8'h41;
        end else if (c inside {[8'h61:8'h7A]}) begin
            v = c - 8'h61 + 8'd26;
        end else if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            v = 8'd62;
        end else if (c == 8'h2F) begin
            v = 8'd63;
        end else begin
            v = 8'd0;
        end
        return v[5:0];
    endfunction

    function automatic logic [7:0] alpha_char(input logic [5:0] s);
        logic [7:0] e;
        logic [7:0] ch;
        e = {2'b00, s};
        if (s < 6'd26) begin
            ch = 8'h41 + e;
        end else if (s < 6'd52) begin
            ch = 8'h61 + e - 8'd26;
        end else if (s < 6'd62) begin
            ch = 8'h30 + e - 8'd52;
        end else if (s == 6'd62) begin
            ch = 8'h2B;
        end else begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

    // Whole bytes carried by a given count of data characters.
    function automatic logic [1:0] bytes_for_data(input logic [2:0] d);
        logic [1:0] nb;
        case (d)
            3'd2:    nb = 2'd1;
            3'd3:    nb = 2'd2;
            3'd4:    nb = 2'd3;
            default: nb = 2'd0;
        endcase
        return nb;
    endfunction

endpackage

[rtl/core/b64sc_front.sv]
module b64sc_front
    import b64sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  logic       push,
    output logic       full,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    output group_job_t job,
    output logic       job_valid,
    input  logic       job_full
);

    logic        dir_reg,   dir_next;
    logic [23:0] bits_reg,  bits_next;
    logic [1:0]  count_reg, count_next;
    logic [1:0]  pad_reg,   pad_next;
    logic        bad_reg,   bad_next;

    logic        accept;
    logic [1:0]  cnt;
    logic [2:0]  cnt1;
    logic [7:0]  b;
    char_class_t cls;
    logic [5:0]  sval;
    logic [23:0] placed;
    logic [23:0] bits_new;
    logic [1:0]  pad_new;
    logic        bad_new;
    logic        complete;
    logic [2:0]  data_cnt;
    logic [1:0]  nb;

    assign cfg_ready = 1'b1;
    assign full      = job_full;
    assign accept    = push && !job_full;

    always_comb
    begin
        b   = item.data_byte;
        cls = classify(b);
        cnt = count_reg;
        // The encoder never holds three bytes; clamp to keep placement bounded.
        if (dir_reg == DIR_ENCODE && cnt == 2'd3) begin
            cnt = 2'd2;
        end
        cnt1 = {1'b0, cnt} + 3'd1;

        pad_new = pad_reg;
        bad_new = bad_reg;
        sval    = 6'd0;
        if (dir_reg == DIR_ENCODE) begin
            case (cnt)
                2'd0:    placed = {b, 16'h0000};
                2'd1:    placed = {8'h00, b, 8'h00};
                default: placed = {16'h0000, b};
            endcase
            complete = (cnt1 == 3'd3) || item.last;
        end else begin
            if (cls == CLS_PAD && pad_reg != 2'd3) begin
                pad_new = pad_reg + 2'd1;
            end
            if (cls == CLS_BAD) begin
                bad_new = 1'b1;
            end
            if (cls == CLS_DATA) begin
                sval = sextet_of(b);
            end
            case (cnt)
                2'd0:    placed = {sval, 18'h0};
                2'd1:    placed = {6'h0, sval, 12'h0};
                2'd2:    placed = {12'h0, sval, 6'h0};
                default: placed = {18'h0, sval};
            endcase
            complete = (cnt1 == 3'd4) || item.last;
        end
        bits_new = bits_reg | placed;

        data_cnt = (cnt1 > {1'b0, pad_new}) ? cnt1 - {1'b0, pad_new} : 3'd0;
        nb       = bytes_for_data(data_cnt);

        job.decode = dir_reg;
        job.bits   = bits_new;
        job.used   = cnt1[1:0];
        job.nbytes = nb;
        job.last   = item.last;
        job.bad    = bad_new;

        // A decode group with no whole byte gives a result only at end of message.
        job_valid = accept && complete && (dir_reg == DIR_ENCODE || nb != 2'd0 || item.last);

        dir_next   = dir_reg;
        bits_next  = bits_reg;
        count_next = count_reg;
        pad_next   = pad_reg;
        bad_next   = bad_reg;
        if (cfg_valid) begin
            dir_next   = cfg_data;
            bits_next  = 24'h0;
            count_next = 2'd0;
            pad_next   = 2'd0;
            bad_next   = 1'b0;
        end else if (accept) begin
            if (complete) begin
                bits_next  = 24'h0;
                count_next = 2'd0;
                pad_next   = 2'd0;
                bad_next   = 1'b0;
            end else begin
                bits_next  = bits_new;
                count_next = cnt1[1:0];
                pad_next   = pad_new;
                bad_next   = bad_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dir_reg   <= DIR_ENCODE;
            bits_reg  <= 24'h0;
            count_reg <= 2'd0;
            pad_reg   <= 2'd0;
            bad_reg   <= 1'b0;
        end else begin
            dir_reg   <= dir_next;
            bits_reg  <= bits_next;
            count_reg <= count_next;
            pad_reg   <= pad_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

[rtl/core/b64sc_queue.sv]
module b64sc_queue
    import b64sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  group_job_t wr_job,
    input  logic       wr_en,
    output logic       q_full,
    output group_job_t rd_job,
    input  logic       rd_en,
    output logic       q_empty
);

    group_job_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_wr;
    logic       do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign rd_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        do_wr       = wr_en && !q_full;
        do_rd       = rd_en && !q_empty;
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 2'd1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/b64sc_back.sv]
module b64sc_back
    import b64sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  group_job_t job,
    input  logic       job_empty,
    output logic       job_pop,
    output out_item_t  result,
    output logic       empty,
    input  logic       pop
);

    logic [1:0] k_reg,         k_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  res_reg;
    out_item_t  res_next;
    logic       load;
    logic       final_step;
    logic [5:0] sext;
    logic [7:0] dbyte;

    assign empty  = !out_valid_reg;
    assign result = res_reg;

    always_comb
    begin
        load = !job_empty && (!out_valid_reg || pop);

        case (k_reg)
            2'd0:    sext = job.bits[23:18];
            2'd1:    sext = job.bits[17:12];
            2'd2:    sext = job.bits[11:6];
            default: sext = job.bits[5:0];
        endcase
        case (k_reg)
            2'd0:    dbyte = job.bits[23:16];
            2'd1:    dbyte = job.bits[15:8];
            default: dbyte = job.bits[7:0];
        endcase

        if (job.decode == DIR_ENCODE) begin
            final_step         = (k_reg == 2'd3);
            res_next.out_byte  = (k_reg <= job.used) ? alpha_char(sext) : PAD_CHAR;
            res_next.out_last  = final_step && job.last;
            res_next.empty_res = 1'b0;
            res_next.bad_char  = 1'b0;
        end else if (job.nbytes == 2'd0) begin
            // End of message with no whole byte left: one empty result.
            final_step         = 1'b1;
            res_next.out_byte  = 8'h00;
            res_next.out_last  = 1'b1;
            res_next.empty_res = 1'b1;
            res_next.bad_char  = job.bad;
        end else begin
            final_step         = (k_reg == job.nbytes - 2'd1);
            res_next.out_byte  = dbyte;
            res_next.out_last  = final_step && job.last;
            res_next.empty_res = 1'b0;
            res_next.bad_char  = job.bad;
        end

        job_pop        = load && final_step;
        k_next         = k_reg;
        if (load) begin
            k_next = final_step ? 2'd0 : k_reg + 2'd1;
        end
        out_valid_next = load || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/core/base64_stream_codec.sv]
// Channel   Handshake                 Payload
// input     push / full               item   (data_byte, last)
// result    empty / pop               result (out_byte, out_last, empty_res, bad_char)
// config    cfg_valid / cfg_ready     cfg_data (direction: 0 encode, 1 decode)
//
// The front end takes one item per cycle whenever the group queue has room.
// The back end writes one result per cycle into the output register while the
// results are popped; an encoded group of three bytes gives four results, so
// encoding cannot sustain one input item per cycle, while decoding can.
// A result shows on the ports once the group it completes has passed through the queue and the output register.
// Reset clears the direction to encode and empties the queue and output register.
// A stalled result holds; the front end keeps accepting until the queue fills.
module base64_stream_codec
    import b64sc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  logic      push,
    output logic      full,
    output out_item_t result,
    output logic      empty,
    input  logic      pop,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    // A finished group travels from the front end to the back end through a
    // two-entry queue, so the input side keeps running while results drain.
    group_job_t wr_job;
    group_job_t rd_job;
    logic       job_valid;
    logic       q_full;
    logic       q_empty;
    logic       job_pop;

    // The front end classifies each item, assembles the group and decides how
    // many results the group gives.
    b64sc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .job       (wr_job),
        .job_valid (job_valid),
        .job_full  (q_full)
    );

    b64sc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_job  (wr_job),
        .wr_en   (job_valid),
        .q_full  (q_full),
        .rd_job  (rd_job),
        .rd_en   (job_pop),
        .q_empty (q_empty)
    );

    // The back end steps through the group one result per cycle while its output
    // register is free or being popped, and holds the oldest result there until it is popped.
    b64sc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (rd_job),
        .job_empty (q_empty),
        .job_pop   (job_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

[rtl/core/b64sc_checker.sv]
module b64sc_checker
    import b64sc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input out_item_t result,
    input logic      empty,
    input logic      pop
);

    // The first cycle out of reset shows no result.
    assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result shown right after reset");

    // An empty result always closes a message and carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.empty_res) |-> (result.out_last && result.out_byte == 8'h00))
        else $error("empty result without end of message");

    // A result that is not taken stays on the ports unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("stalled result changed");

    // An empty result never carries a pad character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.empty_res) |-> !(result.out_byte == PAD_CHAR))
        else $error("empty result carries a pad character");

endmodule

bind base64_stream_codec b64sc_checker u_chk (.*);
